>>> design/stp_pkg.sv
`default_nettype none

package stp_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int PLOT_ROWS      = 60;
  localparam int SAMPLE_W       = 10;

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(PLOT_ROWS);
  localparam int DEC_W  = 8;
  localparam int PROD_W = SAMPLE_W + ROW_W;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 2;

  localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(PLOT_ROWS - 1);

  localparam logic [DEC_W-1:0] DECIMATION_RST   = DEC_W'(1);
  localparam logic [COL_W-1:0] FIRST_COLUMN_RST = COL_W'(21);
  localparam logic [COL_W-1:0] LAST_COLUMN_RST  = COL_W'(120);

  localparam logic [CIDX_W-1:0] CFG_DECIMATION   = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_FIRST_COLUMN = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_LAST_COLUMN  = CIDX_W'(2);

  localparam logic CMD_ERASE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  // Item waiting between the tracker and the output register
  typedef struct packed {
    logic             vld;
    logic             erase;
    logic [ROW_W-1:0] old_row;
    logic [ROW_W-1:0] new_row;
    logic [COL_W-1:0] col;
  } stage_t;

  // What the output register took from the stage this cycle
  typedef struct packed {
    logic erase_taken;
    logic draw_taken;
  } pop_t;

  function automatic logic [ROW_W-1:0] map_row(input logic [SAMPLE_W-1:0] s);
    logic [PROD_W-1:0] prod;
    logic [ROW_W-1:0]  scaled;
    prod   = PROD_W'(s) * PROD_W'(ROW_TOP);
    scaled = prod[PROD_W-1:SAMPLE_W];
    if (scaled > ROW_TOP) begin
      scaled = ROW_TOP;
    end
    return ROW_TOP - scaled;
  endfunction

endpackage

`default_nettype wire

>>> design/stp_track.sv
`default_nettype none

module stp_track import stp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                cfg_write,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire pop_t                pop,
  output stage_t                   stage
);

  logic [DEC_W-1:0]          decimation;
  logic [COL_W-1:0]          first_column;
  logic [COL_W-1:0]          last_column;
  logic [DEC_W-1:0]          sample_count;
  logic [COL_W-1:0]          sweep_column;
  logic [ROW_W-1:0]          drawn_row [SCREEN_COLUMNS];
  logic [SCREEN_COLUMNS-1:0] drawn_valid;
  logic [ROW_W-1:0]          old_row;
  logic                      s_vld;
  logic                      s_erase;
  logic [ROW_W-1:0]          s_new_row;
  logic [COL_W-1:0]          s_col;

  logic                      accept;
  logic [DEC_W:0]            cnt;
  logic                      plot;
  logic [COL_W:0]            col_inc;
  logic [COL_W-1:0]          sweep_column_next;

  // Stage frees up in the cycle its draw command moves to the output register
  assign in_stall = s_vld && !pop.draw_taken;
  assign accept   = in_valid && !in_stall;
  assign cnt      = {1'b0, sample_count} + (DEC_W+1)'(1);
  assign plot     = cnt >= {1'b0, decimation};
  assign col_inc  = {1'b0, sweep_column} + (COL_W+1)'(1);

  always_comb begin
    if (col_inc > {1'b0, last_column}) begin
      sweep_column_next = first_column;
    end else begin
      sweep_column_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation   <= DECIMATION_RST;
      first_column <= FIRST_COLUMN_RST;
      last_column  <= LAST_COLUMN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DECIMATION:   decimation   <= cfg_data[DEC_W-1:0];
        CFG_FIRST_COLUMN: first_column <= cfg_data[COL_W-1:0];
        CFG_LAST_COLUMN:  last_column  <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sweep_column <= FIRST_COLUMN_RST;
      drawn_valid  <= '0;
      s_vld        <= 1'b0;
      s_erase      <= 1'b0;
    end else begin
      if (accept) begin
        sample_count <= plot ? '0 : cnt[DEC_W-1:0];
      end
      if (accept && plot) begin
        sweep_column              <= sweep_column_next;
        drawn_valid[sweep_column] <= 1'b1;
        s_vld                     <= 1'b1;
        s_erase                   <= drawn_valid[sweep_column];
      end else begin
        if (pop.draw_taken) begin
          s_vld <= 1'b0;
        end
        if (pop.erase_taken) begin
          s_erase <= 1'b0;
        end
      end
    end
  end

  // Read-before-write: old_row holds the previous dot of this column
  always_ff @(posedge clk) begin
    if (accept && plot) begin
      old_row                 <= drawn_row[sweep_column];
      drawn_row[sweep_column] <= map_row(sample);
      s_new_row               <= map_row(sample);
      s_col                   <= sweep_column;
    end
  end

  assign stage.vld     = s_vld;
  assign stage.erase   = s_erase;
  assign stage.old_row = old_row;
  assign stage.new_row = s_new_row;
  assign stage.col     = s_col;

endmodule

`default_nettype wire

>>> design/stp_emit.sv
`default_nettype none

module stp_emit import stp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stage_t           stage,
  output pop_t                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  command,
  output logic [ROW_W-1:0]      row,
  output logic [COL_W-1:0]      column,
  output logic                  last
);

  logic load;

  // Output register takes a new transaction when empty or being drained
  assign load            = !out_valid || !out_stall;
  assign pop.erase_taken = load && stage.vld && stage.erase;
  assign pop.draw_taken  = load && stage.vld && !stage.erase;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= stage.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && stage.vld) begin
      column <= stage.col;
      if (stage.erase) begin
        command <= CMD_ERASE;
        row     <= stage.old_row;
        last    <= 1'b0;
      end else begin
        command <= CMD_DRAW;
        row     <= stage.new_row;
        last    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sweep_trace_plotter.sv
// A plotted sample goes through the stage and then the single output register,
// which sends one command a cycle while out_stall is low. A new sample is taken
// when the stage is empty or its draw command moves out; an erase goes first.
// Reset (synchronous, rst high) clears the sample counter, the column valid marks
// and the pipeline, and loads decimation 1, first column 21, last column 120.
`default_nettype none

module sweep_trace_plotter import stp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                cfg_write,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     command,
  output logic [ROW_W-1:0]         row,
  output logic [COL_W-1:0]         column,
  output logic                     last
);

  stage_t stage;
  pop_t   pop;

  stp_track u_track (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .stage     (stage)
  );

  stp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .row       (row),
    .column    (column),
    .last      (last)
  );

endmodule

`default_nettype wire
